>>> rtl/rgm_pkg.sv
// Shared types and constants for the ramped gain mix matrix.
// Used by rgm_datapath, rgm_ctrl and the top level under rtl/; depends on nothing.
package rgm_pkg;

  localparam int ELEMENTS_DEF = 16;
  localparam int CHANNELS_DEF = 16;
  localparam int MAX_OUT      = 16;

  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_RAMP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CH    = 2'd1;

  localparam logic MODE_TARGET = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_TGT,
    ST_CRD,
    ST_CWAIT,
    ST_CDIV,
    ST_SRL,
    ST_SRLW,
    ST_SRD,
    ST_SMUL,
    ST_SWR,
    ST_SDEC,
    ST_ERD,
    ST_EDAT
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic cnt_clr;
    logic cnt_inc;
    logic tgt_wr;
    logic rl_commit;
    logic rl_rd;
    logic rl_cap;
    logic rl_dec;
    logic gain_rd;
    logic commit_wr;
    logic div_start;
    logic step_wr;
    logic mul;
    logic smp_wr;
    logic acc_rd;
    logic emit_wr;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic e_ok;
    logic ch_ok;
    logic last_ch;
    logic last_el;
    logic ramp_zero;
    logic cnt_last;
    logic clr_last;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

>>> rtl/rgm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rgm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/rgm_div.sv
// Radix-2 restoring divider: signed 33-bit dividend by unsigned 20-bit divisor,
// quotient truncated toward zero, low 32 bits. Depends on nothing.
module rgm_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] dividend,
  input  logic [19:0]        divisor,
  output logic               done,
  output logic [31:0]        quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic        neg;
  logic [31:0] dq;
  logic [20:0] rem;
  logic [19:0] dvs;
  logic [32:0] mag;
  logic [20:0] rsh;
  logic        take;

  assign mag  = dividend[32] ? -dividend : dividend;
  assign rsh  = {rem[19:0], dq[31]};
  assign take = rsh >= {1'b0, dvs};
  assign quotient = neg ? -dq : dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= mag[31:0];
      rem <= '0;
      neg <= dividend[32];
      dvs <= divisor;
    end else if (busy) begin
      rem <= take ? (rsh - {1'b0, dvs}) : rsh;
      dq  <= {dq[30:0], take};
    end
  end

endmodule

>>> rtl/rgm_datapath.sv
// Datapath: gain, step, target, ramp and accumulator stores, MAC, divider,
// config registers and output register. Depends on rgm_pkg, rgm_ram, rgm_div.
module rgm_datapath
  import rgm_pkg::*;
#(
  parameter int ELEMENTS = ELEMENTS_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [S_DATA_W-1:0]  s_tdata,
  input  logic                 s_tuser,
  input  logic                 s_tlast,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,
  output logic                 m_tlast
);

  localparam int EC   = ELEMENTS * CHANNELS;
  localparam int AW   = $clog2(EC);
  localparam int EW   = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int CW   = $clog2(CHANNELS);
  localparam int NMAX = (CHANNELS < MAX_OUT) ? CHANNELS : MAX_OUT;

  logic               it_mode;
  logic [3:0]         it_elem;
  logic [3:0]         it_chan;
  logic signed [23:0] it_tgt;
  logic [19:0]        it_rlen;
  logic               it_jump;
  logic               it_lastch;
  logic signed [23:0] it_smp;
  logic               it_sig;
  logic               it_laste;

  logic [19:0] dflt_ramp;
  logic [4:0]  act_ch;
  logic [4:0]  n_used;

  logic [AW-1:0] cnt;
  logic [CW-1:0] chan;
  logic [19:0]   rl;
  logic [19:0]   ramp_val;
  logic signed [55:0] prod;

  logic [23:0] tgt_q;
  logic [31:0] cur_q;
  logic [31:0] stp_q;
  logic [31:0] acc_q;
  logic [19:0] rl_q;
  logic [31:0] tgt16;

  logic [AW-1:0] addr_cnt;
  logic [AW-1:0] addr_item;
  logic [AW-1:0] g_waddr;
  logic          c_in;
  logic          c_lastout;

  logic          tgt_we, cur_we, stp_we, acc_we, rl_we;
  logic [31:0]   cur_wd, stp_wd, acc_wd;
  logic [19:0]   rl_wd;
  logic [EW-1:0] rl_waddr;

  logic signed [32:0] diff;
  logic               div_done;
  logic [31:0]        div_q;
  logic [32:0]        asum;
  logic [31:0]        asat;
  logic               clip;
  logic [23:0]        mixed;

  assign chan      = cnt[CW-1:0];
  assign tgt16     = {{4{tgt_q[23]}}, tgt_q, 4'h0};
  assign ramp_val  = it_jump ? 20'd0 : ((it_rlen != 20'd0) ? it_rlen : dflt_ramp);
  assign addr_cnt  = AW'(32'(it_elem) * CHANNELS + 32'(chan));
  assign addr_item = AW'(32'(it_elem) * CHANNELS + 32'(it_chan));
  assign c_in      = 32'(chan) < 32'(n_used);
  assign c_lastout = (32'(chan) + 1) == 32'(n_used);

  always_comb begin
    priority if (act_ch == 5'd0) begin
      n_used = 5'd1;
    end else if (32'(act_ch) > NMAX) begin
      n_used = 5'(NMAX);
    end else begin
      n_used = act_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dflt_ramp <= '0;
      act_ch    <= 5'd16;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DEFAULT_RAMP) begin
        dflt_ramp <= cfg_data;
      end
      if (cfg_index == REG_ACTIVE_CH) begin
        act_ch <= cfg_data[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_mode   <= s_tuser;
      it_elem   <= s_tdata[3:0];
      it_chan   <= s_tdata[7:4];
      it_tgt    <= s_tdata[31:8];
      it_rlen   <= s_tdata[51:32];
      it_jump   <= s_tdata[52];
      it_lastch <= s_tdata[53];
      it_smp    <= s_tdata[77:54];
      it_sig    <= s_tdata[78];
      it_laste  <= s_tlast;
    end
    if (cmd.rl_cap) begin
      rl <= rl_q;
    end
    if (cmd.mul) begin
      prod <= it_smp * $signed(cur_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + AW'(1);
    end
  end

  // divider
  assign diff = $signed({tgt16[31], tgt16}) - $signed({cur_q[31], cur_q});

  rgm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (diff),
    .divisor  (ramp_val),
    .done     (div_done),
    .quotient (div_q)
  );

  // accumulate with 32-bit saturation
  assign asum = {acc_q[31], acc_q} + {prod[55], prod[55:24]};
  assign asat = (asum[32] != asum[31]) ? (asum[32] ? 32'h8000_0000 : 32'h7fff_ffff)
                                       : asum[31:0];

  // store write control
  assign g_waddr = cmd.clr_wr ? cnt : (cmd.tgt_wr ? addr_item : addr_cnt);
  assign tgt_we  = cmd.clr_wr | cmd.tgt_wr;
  assign cur_we  = cmd.clr_wr | cmd.commit_wr | (cmd.smp_wr & (rl != 20'd0));
  assign stp_we  = cmd.clr_wr | cmd.commit_wr | cmd.step_wr;
  assign acc_we  = (cmd.clr_wr & (32'(cnt) < CHANNELS)) | (cmd.smp_wr & it_sig & c_in)
                 | cmd.emit_wr;
  assign rl_we   = (cmd.clr_wr & (32'(cnt) < ELEMENTS)) | cmd.rl_commit
                 | (cmd.rl_dec & (rl != 20'd0));

  always_comb begin
    priority if (cmd.clr_wr) begin
      cur_wd = '0;
    end else if (cmd.commit_wr || rl == 20'd1) begin
      cur_wd = tgt16;
    end else begin
      cur_wd = cur_q + stp_q;
    end
  end

  assign stp_wd   = (cmd.clr_wr | cmd.commit_wr) ? 32'd0 : div_q;
  assign acc_wd   = cmd.smp_wr ? asat : 32'd0;
  assign rl_wd    = cmd.clr_wr ? 20'd0 : (cmd.rl_commit ? ramp_val : rl - 20'd1);
  assign rl_waddr = cmd.clr_wr ? EW'(cnt) : EW'(it_elem);

  rgm_ram #(.WIDTH(24), .DEPTH(EC)) u_tgt (
    .clk(clk), .wr_en(tgt_we), .wr_addr(g_waddr),
    .wr_data(cmd.clr_wr ? 24'd0 : it_tgt),
    .rd_en(cmd.gain_rd), .rd_addr(addr_cnt), .rd_data(tgt_q)
  );

  rgm_ram #(.WIDTH(32), .DEPTH(EC)) u_cur (
    .clk(clk), .wr_en(cur_we), .wr_addr(g_waddr), .wr_data(cur_wd),
    .rd_en(cmd.gain_rd), .rd_addr(addr_cnt), .rd_data(cur_q)
  );

  rgm_ram #(.WIDTH(32), .DEPTH(EC)) u_stp (
    .clk(clk), .wr_en(stp_we), .wr_addr(g_waddr), .wr_data(stp_wd),
    .rd_en(cmd.gain_rd), .rd_addr(addr_cnt), .rd_data(stp_q)
  );

  rgm_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_acc (
    .clk(clk), .wr_en(acc_we), .wr_addr(chan), .wr_data(acc_wd),
    .rd_en(cmd.gain_rd | cmd.acc_rd), .rd_addr(chan), .rd_data(acc_q)
  );

  rgm_ram #(.WIDTH(20), .DEPTH(ELEMENTS)) u_rl (
    .clk(clk), .wr_en(rl_we), .wr_addr(rl_waddr), .wr_data(rl_wd),
    .rd_en(cmd.rl_rd), .rd_addr(EW'(it_elem)), .rd_data(rl_q)
  );

  // emission with 24-bit saturation
  assign clip  = (acc_q[31:23] != 9'h000) && (acc_q[31:23] != 9'h1ff);
  assign mixed = clip ? (acc_q[31] ? 24'h80_0000 : 24'h7f_ffff) : acc_q[23:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_wr && c_in) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_wr && c_in) begin
      m_tdata <= {3'b000, clip, mixed, 4'(chan)};
      m_tlast <= c_lastout;
    end
  end

  assign sts.mode      = it_mode;
  assign sts.e_ok      = 32'(it_elem) < ELEMENTS;
  assign sts.ch_ok     = 32'(it_chan) < CHANNELS;
  assign sts.last_ch   = it_lastch;
  assign sts.last_el   = it_laste;
  assign sts.ramp_zero = ramp_val == 20'd0;
  assign sts.cnt_last  = chan == CW'(CHANNELS - 1);
  assign sts.clr_last  = cnt == AW'(EC - 1);
  assign sts.div_done  = div_done;
  assign sts.out_busy  = m_tvalid;

endmodule

>>> rtl/rgm_ctrl.sv
// Controller: sequences clearing, target commits, sample MAC/ramp passes
// and emission over the channel loop. Depends on rgm_pkg.
module rgm_ctrl
  import rgm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load    = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (sts.mode == MODE_TARGET) begin
          state_next = sts.e_ok ? ST_TGT : ST_IDLE;
        end else if (sts.e_ok) begin
          state_next = ST_SRL;
        end else begin
          state_next = sts.last_el ? ST_ERD : ST_IDLE;
        end
      end
      ST_TGT: begin
        cmd.tgt_wr = sts.ch_ok;
        if (sts.last_ch) begin
          cmd.rl_commit = 1'b1;
          state_next    = ST_CRD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CRD: begin
        cmd.gain_rd = 1'b1;
        state_next  = ST_CWAIT;
      end
      ST_CWAIT: begin
        if (sts.ramp_zero) begin
          cmd.commit_wr = 1'b1;
          if (sts.cnt_last) begin
            cmd.cnt_clr = 1'b1;
            state_next  = ST_IDLE;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_next  = ST_CRD;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_CDIV;
        end
      end
      ST_CDIV: begin
        if (sts.div_done) begin
          cmd.step_wr = 1'b1;
          if (sts.cnt_last) begin
            cmd.cnt_clr = 1'b1;
            state_next  = ST_IDLE;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_next  = ST_CRD;
          end
        end
      end
      ST_SRL: begin
        cmd.rl_rd  = 1'b1;
        state_next = ST_SRLW;
      end
      ST_SRLW: begin
        cmd.rl_cap = 1'b1;
        state_next = ST_SRD;
      end
      ST_SRD: begin
        cmd.gain_rd = 1'b1;
        state_next  = ST_SMUL;
      end
      ST_SMUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SWR;
      end
      ST_SWR: begin
        cmd.smp_wr = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_SDEC;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = ST_SRD;
        end
      end
      ST_SDEC: begin
        cmd.rl_dec = 1'b1;
        state_next = sts.last_el ? ST_ERD : ST_IDLE;
      end
      ST_ERD: begin
        if (!sts.out_busy) begin
          cmd.acc_rd = 1'b1;
          state_next = ST_EDAT;
        end
      end
      ST_EDAT: begin
        cmd.emit_wr = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = ST_ERD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/ramped_gain_mix_matrix_unit.sv
// Ramped gain mixing matrix, top level: ties controller and datapath together.
// Depends on rgm_pkg, rgm_ctrl and rgm_datapath.
//
// One request is handled at a time; every pass walks the channel loop of one
// shared MAC and one set of store ports. A target request without commit
// writes only the target store; a commit walks every channel, loading the
// target at once on a jump or zero ramp, otherwise a step from the 32-step
// divider per channel. A sample request takes three steps per channel for
// store read, multiply and write back; with last_element set, emission walks
// the channels again, waiting on each result while the output register is
// still full, and so on any wait on m_tready. After reset a clearing pass
// over all ELEMENTS*CHANNELS store entries zeroes the stores, during which
// s_tready stays low; configuration writes are taken at any time.
module ramped_gain_mix_matrix_unit
  import rgm_pkg::*;
#(
  parameter int ELEMENTS = ELEMENTS_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // element[3:0] channel[7:4] target_gain[31:8] ramp_length[51:32] jump[52]
  // last_channel[53] sample_value[77:54] sig_present[78] zero[79]
  input  logic [S_DATA_W-1:0]  s_tdata,
  // mode
  input  logic                 s_tuser,
  // last_element
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // out_channel[3:0] mixed_sample[27:4] clipped[28] zero[31:29]
  output logic [M_DATA_W-1:0]  m_tdata,
  // last
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  rgm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rgm_datapath #(.ELEMENTS(ELEMENTS), .CHANNELS(CHANNELS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while previous one in progress");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("request taken before clearing pass");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_wr |-> !$past(m_tvalid) || $past(m_tready))
    else $error("output register overwritten");
`endif

endmodule

>>> verif/ramped_gain_mix_matrix_unit_checker.sv
// Checker for ramped_gain_mix_matrix_unit: watches the request, result and config channels,
// keeps its own copy of the gain matrix and mix state, and compares channel, mixed sample, clipped and last.
// Depends on rgm_pkg.
`timescale 1ns / 100ps

module ramped_gain_mix_matrix_unit_checker
  import rgm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,
  input  logic                 s_tuser,
  input  logic                 s_tlast,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_DATA_W-1:0]  m_tdata,
  input  logic                 m_tlast,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   pending
);

  localparam int NE = ELEMENTS_DEF;
  localparam int NC = CHANNELS_DEF;
  localparam longint ACC_MAX = 64'sd2147483647;
  localparam longint ACC_MIN = -64'sd2147483648;

  typedef struct {
    logic [3:0]  ch;
    logic [23:0] mix;
    logic        clip;
    logic        last;
  } mix_out_t;

  logic signed [23:0] gain_target [NE*NC];
  logic signed [31:0] gain_now    [NE*NC];
  logic signed [31:0] gain_step   [NE*NC];
  logic [19:0]        ramp_cnt    [NE];
  logic signed [31:0] mix_acc     [NC];
  logic [19:0]        ramp_default;
  logic [4:0]         active_ch;
  mix_out_t           mix_due [$];

  task automatic report(string what, longint got, longint want);
    $display("%0t: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic commit_gains(int e, logic [19:0] ramp);
    longint diff;
    for (int c = 0; c < NC; c++) begin
      if (ramp == 0) begin
        gain_now[e*NC+c] = 32'(longint'(gain_target[e*NC+c]) * 16);
        gain_step[e*NC+c] = 0;
      end else begin
        diff = longint'(gain_target[e*NC+c]) * 16 - longint'(gain_now[e*NC+c]);
        gain_step[e*NC+c] = 32'(diff / longint'(ramp));
      end
    end
    ramp_cnt[e] = ramp;
  endtask

  task automatic apply_request(logic [S_DATA_W-1:0] d, logic md, logic le);
    int e;
    int n;
    longint smp;
    longint a;
    logic [19:0] rl;
    mix_out_t r;
    e = d[3:0];
    if (md == MODE_TARGET) begin
      gain_target[e*NC + d[7:4]] = d[31:8];
      if (d[53]) begin
        rl = d[51:32];
        commit_gains(e, d[52] ? 20'd0 : (rl != 0 ? rl : ramp_default));
      end
      return;
    end
    n = (active_ch < 1) ? 1 : (active_ch > NC ? NC : active_ch);
    if (d[78]) begin
      smp = $signed(d[77:54]);
      for (int c = 0; c < n; c++) begin
        a = longint'(mix_acc[c]) + ((smp * longint'(gain_now[e*NC+c])) >>> 24);
        if (a > ACC_MAX) a = ACC_MAX;
        if (a < ACC_MIN) a = ACC_MIN;
        mix_acc[c] = a[31:0];
      end
    end
    if (ramp_cnt[e] != 0) begin
      for (int c = 0; c < NC; c++) gain_now[e*NC+c] = gain_now[e*NC+c] + gain_step[e*NC+c];
      ramp_cnt[e] = ramp_cnt[e] - 1;
      if (ramp_cnt[e] == 0)
        for (int c = 0; c < NC; c++) gain_now[e*NC+c] = 32'(longint'(gain_target[e*NC+c]) * 16);
    end
    if (!le) return;
    for (int c = 0; c < n; c++) begin
      a = mix_acc[c];
      r.clip = 1'b0;
      if (a > 8388607) begin a = 8388607; r.clip = 1'b1; end
      if (a < -8388608) begin a = -8388608; r.clip = 1'b1; end
      r.ch = c[3:0];
      r.mix = a[23:0];
      r.last = (c + 1 == n);
      mix_due = {mix_due, r};
    end
    for (int c = 0; c < NC; c++) mix_acc[c] = 0;
  endtask

  always @(posedge clk) begin
    mix_out_t w;
    if (rst) begin
      for (int i = 0; i < NE*NC; i++) begin
        gain_target[i] = 0;
        gain_now[i] = 0;
        gain_step[i] = 0;
      end
      for (int i = 0; i < NE; i++) ramp_cnt[i] = 0;
      for (int i = 0; i < NC; i++) mix_acc[i] = 0;
      ramp_default = 0;
      active_ch = 16;
      mix_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DEFAULT_RAMP) ramp_default = cfg_data;
        else if (cfg_index == REG_ACTIVE_CH) active_ch = cfg_data[4:0];
      end
      if (m_tvalid && m_tready) begin
        if (mix_due.size() == 0) begin
          report("unexpected result, channel", m_tdata[3:0], -1);
        end else begin
          w = mix_due.pop_front();
          if (m_tdata[3:0] !== w.ch) report("out_channel", m_tdata[3:0], w.ch);
          if (m_tdata[27:4] !== w.mix)
            report("mixed_sample", $signed(m_tdata[27:4]), $signed(w.mix));
          if (m_tdata[28] !== w.clip) report("clipped", m_tdata[28], w.clip);
          if (m_tlast !== w.last) report("last", m_tlast, w.last);
        end
      end
      if (s_tvalid && s_tready) apply_request(s_tdata, s_tuser, s_tlast);
    end
    pending = mix_due.size();
  end

endmodule

>>> verif/ramped_gain_mix_matrix_unit_tb.sv
// Testbench top for ramped_gain_mix_matrix_unit: drives directed and random requests,
// config writes and output stalls, and gives the verdict from the checker's counts.
// Depends on rgm_pkg, ramped_gain_mix_matrix_unit and ramped_gain_mix_matrix_unit_checker.
`timescale 1ns / 100ps

module ramped_gain_mix_matrix_unit_tb;
  import rgm_pkg::*;

  localparam int LIMIT = 3000000;
  localparam int SETTLE = 1200;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  int fail_count;
  int pending;
  int cycles = 0;
  int sent = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  ramped_gain_mix_matrix_unit uut (.*);
  ramped_gain_mix_matrix_unit_checker chk (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("ramped_gain_mix_matrix_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk)
    m_tready <= rx_stall_pct == 0 || $urandom_range(99) >= rx_stall_pct;

  task automatic send(logic md, logic [3:0] e, logic [3:0] ch, logic [23:0] tgt,
                      logic [19:0] rl, logic jmp, logic lc, logic [23:0] smp,
                      logic hs, logic le);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= md;
    s_tlast <= le;
    s_tdata <= {1'b0, hs, smp, lc, jmp, rl, tgt, ch, e};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic gain_req(logic [3:0] e, logic [3:0] ch, logic [23:0] tgt,
                          logic [19:0] rl, logic jmp, logic lc);
    send(MODE_TARGET, e, ch, tgt, rl, jmp, lc, 24'($urandom), 1'($urandom_range(1)),
         1'($urandom_range(1)));
  endtask

  task automatic sample_req(logic [3:0] e, logic [23:0] smp, logic hs, logic le);
    send(MODE_SAMPLE, e, 4'($urandom), 24'($urandom), 20'($urandom),
         1'($urandom_range(1)), 1'($urandom_range(1)), smp, hs, le);
  endtask

  task automatic settle;
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [19:0] pick_ramp();
    int r;
    r = $urandom_range(9);
    if (r < 3) return 20'd0;
    if (r == 9) return 20'($urandom);
    return 20'($urandom_range(1, 8));
  endfunction

  function automatic logic [23:0] pick_level();
    logic [23:0] v;
    v = 24'($urandom);
    if ($urandom_range(2) == 0) v = 24'($signed(v) >>> $urandom_range(1, 12));
    return v;
  endfunction

  task automatic random_burst;
    int r;
    int k;
    logic [3:0] e;
    r = $urandom_range(99);
    if (r < 35) begin
      e = 4'($urandom);
      k = $urandom_range(1, 4);
      for (int i = 0; i < k; i++)
        gain_req(e, 4'($urandom), pick_level(), pick_ramp(), $urandom_range(4) == 0,
                 i == k - 1);
    end else if (r < 85) begin
      k = $urandom_range(1, 5);
      for (int i = 0; i < k; i++)
        sample_req(4'($urandom), pick_level(), $urandom_range(9) != 0, i == k - 1);
    end else begin
      send(1'($urandom_range(1)), 4'($urandom), 4'($urandom), 24'($urandom),
           20'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)), 24'($urandom),
           1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic pileup;
    for (int c = 0; c < 16; c++) gain_req(4'd5, 4'(c), 24'h7FFFFF, 20'd0, 1'b1, c == 15);
    for (int i = 0; i < 35; i++) sample_req(4'd5, 24'h800000, 1'b1, i == 34);
  endtask

  initial begin
    int tx_pct [4] = '{0, 70, 0, 29};
    int rx_pct [4] = '{0, 0, 70, 29};
    logic [19:0] ramp_set [4] = '{20'd3, 20'hFFFFF, 20'd0, 20'd7};
    logic [4:0]  ch_set   [4] = '{5'd16, 5'd1, 5'd0, 5'd31};
    int goal;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset config: default ramp 0, all 16 channels
    gain_req(4'd0, 4'd0, 24'h7FFFFF, 20'd0, 1'b0, 1'b0);
    gain_req(4'd0, 4'd1, 24'h800000, 20'd0, 1'b0, 1'b0);
    gain_req(4'd0, 4'd15, 24'h100000, 20'd0, 1'b0, 1'b1);
    sample_req(4'd0, 24'h7FFFFF, 1'b1, 1'b0);
    sample_req(4'd0, 24'h800000, 1'b1, 1'b1);
    gain_req(4'd1, 4'd2, 24'h080000, 20'd3, 1'b0, 1'b1);
    repeat (4) sample_req(4'd1, 24'h400000, 1'b1, 1'b1);
    sample_req(4'd1, 24'h7FFFFF, 1'b0, 1'b1);
    gain_req(4'd2, 4'd0, 24'hF00000, 20'hFFFFF, 1'b1, 1'b1);
    gain_req(4'd3, 4'd3, 24'd123456, 20'hFFFFF, 1'b0, 1'b1);
    sample_req(4'd3, 24'hFFFFFF, 1'b1, 1'b0);
    sample_req(4'd2, 24'h000001, 1'b1, 1'b1);
    settle();
    cfg_write(REG_DEFAULT_RAMP, 20'd4);
    gain_req(4'd4, 4'd5, 24'h7FFFFF, 20'd0, 1'b0, 1'b1);
    repeat (5) sample_req(4'd4, 24'h7FFFFF, 1'b1, 1'b1);

    for (int p = 0; p < 4; p++) begin
      settle();
      cfg_write(REG_DEFAULT_RAMP, ramp_set[p]);
      cfg_write(REG_ACTIVE_CH, 20'(ch_set[p]));
      tx_idle_pct = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      if (p == 0) pileup();
      goal = sent + 48;
      while (sent < goal) random_burst();
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("ramped_gain_mix_matrix_unit verification clean");
    end else begin
      $display("ramped_gain_mix_matrix_unit verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rgm_pkg.sv
rtl/rgm_ram.sv
rtl/rgm_div.sv
rtl/rgm_datapath.sv
rtl/rgm_ctrl.sv
rtl/ramped_gain_mix_matrix_unit.sv
verif/ramped_gain_mix_matrix_unit_checker.sv
verif/ramped_gain_mix_matrix_unit_tb.sv
